/* rtl/lgst_pkg.sv */
package lgst_pkg;

	localparam int CFG_W = 20;
	localparam int TICK_W = 32;

	localparam logic [1:0] REG_IDLE_LEVEL    = 2'd0;
	localparam logic [1:0] REG_GATE_SPACING  = 2'd1;
	localparam logic [1:0] REG_COIL_DISTANCE = 2'd2;

	localparam logic [CFG_W-1:0] GATE_SPACING_RST  = 20'd50000;
	localparam logic [CFG_W-1:0] COIL_DISTANCE_RST = 20'd100000;

	typedef struct packed {
		logic beam_one;
		logic beam_two;
	} in_t;

	typedef struct packed {
		logic              forward;
		logic [TICK_W-1:0] transit_ticks;
		logic [TICK_W-1:0] trigger_delay;
		logic              saturated;
	} out_t;

	typedef enum logic [3:0] {
		ST_WAIT_IDLE,
		ST_ARMED,
		ST_COUNTING,
		ST_REV_TWO,
		ST_REV_WATCH,
		ST_REV_ONE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic cnt_clear;
		logic cnt_inc;
		logic capture;
		logic mul_load;
		logic div_step;
		logic load_fwd;
		logic load_rev;
	} cmd_t;

	typedef struct packed {
		logic one_broken;
		logic two_broken;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

/* rtl/light_gate_speed_trigger_unit.sv */
// Results: a rejection is registered and shown in the cycle after the sample that causes it;
//   a forward result follows the sample where beam two breaks, through the transit capture,
//   the multiply, the restoring divider and the result load, which waits for a free output.
// Throughput: one sample per cycle while counting and no result is stalled; none while dividing.
// Reset: arst_n clears the state machine, tick counter and result valid; registers return
//   to idle_level 1, gate_spacing 50000, coil_distance 100000.
module light_gate_speed_trigger_unit
	import lgst_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
)(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CNT_W = (COUNT_WIDTH < TICK_W) ? COUNT_WIDTH : TICK_W;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	cmd_t  cmd;
	stat_t stat;
	logic  sample_ready;
	logic  busy;
	logic  accept;

	assign in_stall = !sample_ready || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;

	lgst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.stat         (stat),
		.cmd          (cmd),
		.sample_ready (sample_ready),
		.busy         (busy)
	);

	lgst_dp #(
		.CNT_W (CNT_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("sample taken during delay computation");

	a_rev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.forward) |->
		(out_data.transit_ticks == '0 && out_data.trigger_delay == '0 && !out_data.saturated))
		else $error("reverse transaction carries nonzero fields");

	a_delay_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.trigger_delay <= TICK_W'(CNT_MAX) &&
			out_data.transit_ticks <= TICK_W'(CNT_MAX)))
		else $error("result exceeds count maximum");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.forward && out_data.transit_ticks == TICK_W'(CNT_MAX)) |->
		out_data.saturated)
		else $error("clipped transit not flagged");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_fwd && cmd.load_rev))
		else $error("two result loads at once");

endmodule

/* rtl/lgst_ctrl.sv */
module lgst_ctrl
	import lgst_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  stat_t  stat,
	output cmd_t   cmd,
	output logic   sample_ready,
	output logic   busy
);

	state_t state_q, state_d;
	logic   second_cleared_q, second_cleared_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_WAIT_IDLE;
			second_cleared_q <= 1'b0;
		end else begin
			state_q          <= state_d;
			second_cleared_q <= second_cleared_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		second_cleared_d = second_cleared_q;
		unique case (state_q)
			ST_WAIT_IDLE: begin
				if (accept && !stat.one_broken && !stat.two_broken) state_d = ST_ARMED;
			end
			ST_ARMED: begin
				if (accept) begin
					if (stat.one_broken) begin
						second_cleared_d = !stat.two_broken;
						state_d          = ST_COUNTING;
					end else if (stat.two_broken) begin
						state_d = ST_REV_TWO;
					end
				end
			end
			ST_COUNTING: begin
				if (accept) begin
					if (!second_cleared_q) begin
						if (!stat.two_broken) second_cleared_d = 1'b1;
					end else if (stat.two_broken) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_REV_TWO: begin
				if (accept && !stat.two_broken) state_d = ST_REV_WATCH;
			end
			ST_REV_WATCH: begin
				if (accept) begin
					if (stat.two_broken) begin
						state_d          = ST_WAIT_IDLE;
						second_cleared_d = 1'b0;
					end else if (stat.one_broken) begin
						state_d = ST_REV_ONE;
					end
				end
			end
			ST_REV_ONE: begin
				if (accept && !stat.one_broken) begin
					state_d          = ST_WAIT_IDLE;
					second_cleared_d = 1'b0;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					state_d          = ST_WAIT_IDLE;
					second_cleared_d = 1'b0;
				end
			end
			default: begin
				state_d = ST_WAIT_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_ready = 1'b0;
		busy         = 1'b0;
		unique case (state_q)
			ST_WAIT_IDLE: begin
				sample_ready = 1'b1;
			end
			ST_ARMED: begin
				sample_ready  = 1'b1;
				cmd.cnt_clear = accept && stat.one_broken;
			end
			ST_COUNTING: begin
				sample_ready = 1'b1;
				cmd.cnt_inc  = accept;
				cmd.capture  = accept && second_cleared_q && stat.two_broken;
			end
			ST_REV_TWO: begin
				sample_ready = 1'b1;
			end
			ST_REV_WATCH: begin
				sample_ready = 1'b1;
				cmd.load_rev = accept && stat.two_broken;
			end
			ST_REV_ONE: begin
				sample_ready = 1'b1;
				cmd.load_rev = accept && !stat.one_broken;
			end
			ST_MUL: begin
				busy         = 1'b1;
				cmd.mul_load = 1'b1;
			end
			ST_DIV: begin
				busy         = 1'b1;
				cmd.div_step = 1'b1;
			end
			ST_DONE: begin
				busy         = 1'b1;
				cmd.load_fwd = stat.out_free;
			end
			default: begin
				sample_ready = 1'b1;
			end
		endcase
	end

endmodule

/* rtl/lgst_dp.sv */
module lgst_dp
	import lgst_pkg::*;
#(
	parameter int CNT_W = 32
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_t                  in_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data
);

	localparam int PROD_W = CFG_W + CNT_W;
	localparam int DIV_CW = $clog2(PROD_W);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic              idle_q;
	logic [CFG_W-1:0]  spacing_q;
	logic [CFG_W-1:0]  coil_q;

	logic [CNT_W-1:0]  tick_q;
	logic [CNT_W-1:0]  tick_inc;
	logic [CNT_W-1:0]  transit_q;
	logic              count_sat_q;

	logic [PROD_W-1:0] pq_q;
	logic [CFG_W-1:0]  rem_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [CFG_W:0]    rem_shift;
	logic              rem_ge;
	logic [CFG_W-1:0]  rem_next;

	logic              out_valid_q;
	out_t              out_q;
	logic              quo_over;
	logic [TICK_W-1:0] delay_val;
	logic              delay_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q    <= 1'b1;
			spacing_q <= GATE_SPACING_RST;
			coil_q    <= COIL_DISTANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IDLE_LEVEL:    idle_q    <= cfg_data[0];
				REG_GATE_SPACING:  spacing_q <= cfg_data;
				REG_COIL_DISTANCE: coil_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stat.one_broken = in_data.beam_one != idle_q;
	assign stat.two_broken = in_data.beam_two != idle_q;

	// saturating tick counter
	assign tick_inc = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (cmd.cnt_clear) begin
			tick_q <= '0;
		end else if (cmd.cnt_inc) begin
			tick_q <= tick_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			transit_q   <= tick_inc;
			count_sat_q <= (tick_inc == CNT_MAX);
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_shift = {rem_q, pq_q[PROD_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, spacing_q};
	assign rem_next  = rem_ge ? CFG_W'(rem_shift - {1'b0, spacing_q}) : rem_shift[CFG_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			pq_q      <= PROD_W'(coil_q) * PROD_W'(transit_q);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			pq_q      <= {pq_q[PROD_W-2:0], rem_ge};
			rem_q     <= rem_next;
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	assign stat.div_done = div_cnt_q == DIV_CW'(PROD_W - 1);

	assign quo_over = pq_q > PROD_W'(CNT_MAX);

	always_comb begin
		if (spacing_q == '0) begin
			delay_val = TICK_W'(CNT_MAX);
			delay_sat = 1'b1;
		end else if (quo_over) begin
			delay_val = TICK_W'(CNT_MAX);
			delay_sat = 1'b1;
		end else begin
			delay_val = TICK_W'(pq_q[CNT_W-1:0]);
			delay_sat = 1'b0;
		end
	end

	// result register
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_fwd || cmd.load_rev) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_fwd) begin
			out_q.forward       <= 1'b1;
			out_q.transit_ticks <= TICK_W'(transit_q);
			out_q.trigger_delay <= delay_val;
			out_q.saturated     <= count_sat_q || delay_sat;
		end else if (cmd.load_rev) begin
			out_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
